>>> hdl/ymodem_receiver_flash_loader_core_macros.svh
// assertion macros for the ymodem receiver flash loader core
// expects i_clk and i_rst_n in the scope of use
`ifndef YMODEM_RECEIVER_FLASH_LOADER_CORE_MACROS_SVH
`define YMODEM_RECEIVER_FLASH_LOADER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define YM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ymrfl assertion failed");
`define YM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ymrfl assertion failed");
`else
`define YM_ASSERT_IMP(lbl, ante, cons)
`define YM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/ymrfl_pkg.sv
// shared types, codes and crc function for the ymodem receiver flash loader
// no dependencies
`default_nettype none
package ymrfl_pkg;
    localparam int LONG_PAYLOAD_DEF = 1024;
    localparam int SHORT_PAYLOAD    = 128;
    localparam int MAX_FRAME_DEF    = 2048;

    localparam logic [7:0] T_SOH = 8'h01;
    localparam logic [7:0] T_STX = 8'h02;
    localparam logic [7:0] T_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_EOT2  = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_JUMP  = 2'd3;

    localparam logic [2:0] CMD_C     = 3'd0;
    localparam logic [2:0] CMD_NAK   = 3'd1;
    localparam logic [2:0] CMD_ACK_C = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_END   = 3'd4;
    localparam logic [2:0] CMD_DATA  = 3'd5;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_PAGES  = 2'd2;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [15:0] pages;
        logic        is_long;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage
`default_nettype wire

>>> hdl/ymrfl_front.sv
// front end: frame byte parsing, crc, header check and frame-end decision
// depends on ymrfl_pkg
`default_nettype none
module ymrfl_front #(
    parameter int LONG_PAYLOAD = ymrfl_pkg::LONG_PAYLOAD_DEF,
    parameter int MAX_FRAME    = ymrfl_pkg::MAX_FRAME_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic                            i_action,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire logic                            i_frame_end,
    input  wire logic                            i_update_enable,
    input  wire logic [31:0]                     i_image_base,
    input  wire logic [15:0]                     i_erase_page_count,
    output ymrfl_pkg::t_cmd                      o_cmd,
    output logic                                 o_push,
    output logic                                 o_wr_en,
    output logic [$clog2(LONG_PAYLOAD)-1:0]      o_wr_addr,
    output logic [7:0]                           o_wr_data
);
    import ymrfl_pkg::*;

    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam int AW = $clog2(LONG_PAYLOAD);
    localparam logic [PW-1:0] P_LONG  = PW'(LONG_PAYLOAD);
    localparam logic [PW-1:0] P_SHORT = PW'(SHORT_PAYLOAD);
    localparam logic [PW-1:0] P_MAX   = PW'(MAX_FRAME);

    logic [1:0]    r_phase, n_phase;
    logic [15:0]   r_exp, n_exp;
    logic [PW-1:0] r_bi, n_bi;
    logic [7:0]    r_ft, n_ft, r_hb, n_hb, r_hc, n_hc;
    logic [15:0]   r_crc, n_crc, r_rcv, n_rcv;

    logic [PW-1:0]    w_q, w_plen, w_cnt;
    logic [15:0]      w_blk;
    logic [15+PW:0]   w_prod;

    assign w_blk  = r_exp - 16'd1;
    assign w_prod = w_blk * w_plen;
    assign w_q    = r_bi - PW'(3);

    always_comb begin
        n_phase   = r_phase;
        n_exp     = r_exp;
        n_bi      = r_bi;
        n_ft      = r_ft;
        n_hb      = r_hb;
        n_hc      = r_hc;
        n_crc     = r_crc;
        n_rcv     = r_rcv;
        w_plen    = '0;
        w_cnt     = r_bi;
        o_push    = 1'b0;
        o_cmd     = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = w_q[AW-1:0];
        o_wr_data = i_rx_byte;
        if (i_accept && i_update_enable) begin
            if (i_action) begin
                if (r_phase == PH_START) begin
                    o_push = 1'b1;
                    o_cmd.op = CMD_C;
                end
            end else begin
                if (r_bi == '0) begin
                    n_ft  = i_rx_byte;
                    n_crc = '0;
                    n_rcv = '0;
                end else if (r_bi == PW'(1)) begin
                    n_hb = i_rx_byte;
                end else if (r_bi == PW'(2)) begin
                    n_hc = i_rx_byte;
                end
                if (n_ft == T_SOH) begin
                    w_plen = P_SHORT;
                end else if (n_ft == T_STX) begin
                    w_plen = P_LONG;
                end
                if (w_plen != '0 && r_bi >= PW'(3)) begin
                    if (w_q < w_plen) begin
                        o_wr_en = 1'b1;
                        n_crc   = crc_byte(n_crc, i_rx_byte);
                    end else if (w_q == w_plen) begin
                        n_rcv = {i_rx_byte, 8'h00};
                    end else if (w_q == w_plen + PW'(1)) begin
                        n_rcv = n_rcv | {8'h00, i_rx_byte};
                    end
                end
                if (r_bi < P_MAX) begin
                    n_bi = r_bi + PW'(1);
                end
                w_cnt = n_bi;
                if (i_frame_end) begin
                    n_bi = '0;
                    if (n_ft == T_EOT) begin
                        if (r_phase == PH_DATA) begin
                            n_phase  = PH_EOT2;
                            o_push   = 1'b1;
                            o_cmd.op = CMD_NAK;
                        end else if (r_phase == PH_EOT2) begin
                            n_phase  = PH_END;
                            o_push   = 1'b1;
                            o_cmd.op = CMD_ACK_C;
                        end
                    end else if (w_plen != '0 && w_cnt >= w_plen + PW'(5) &&
                                 n_crc == n_rcv && n_hc == ~n_hb) begin
                        if (r_phase == PH_START && n_hb == 8'h00) begin
                            n_phase     = PH_DATA;
                            n_exp       = 16'd1;
                            o_push      = 1'b1;
                            o_cmd.op    = CMD_START;
                            o_cmd.addr  = i_image_base;
                            o_cmd.pages = i_erase_page_count;
                        end else if (r_phase == PH_END && n_hb == 8'h00) begin
                            n_phase    = PH_START;
                            o_push     = 1'b1;
                            o_cmd.op   = CMD_END;
                            o_cmd.addr = i_image_base;
                        end else if (r_phase == PH_DATA && n_hb == r_exp[7:0]) begin
                            n_exp         = r_exp + 16'd1;
                            o_push        = 1'b1;
                            o_cmd.op      = CMD_DATA;
                            o_cmd.addr    = i_image_base + 32'(w_prod);
                            o_cmd.is_long = (n_ft == T_STX);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_exp   <= '0;
            r_bi    <= '0;
            r_ft    <= '0;
            r_hb    <= '0;
            r_hc    <= '0;
            r_crc   <= '0;
            r_rcv   <= '0;
        end else begin
            r_phase <= n_phase;
            r_exp   <= n_exp;
            r_bi    <= n_bi;
            r_ft    <= n_ft;
            r_hb    <= n_hb;
            r_hc    <= n_hc;
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
        end
    end
endmodule
`default_nettype wire

>>> hdl/ymrfl_queue.sv
// two-entry command queue between front and back
// depends on ymrfl_pkg
`default_nettype none
module ymrfl_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  ymrfl_pkg::t_cmd      i_data,
    input  wire logic            i_pop,
    output ymrfl_pkg::t_cmd      o_data,
    output logic                 o_empty,
    output logic                 o_full
);
    import ymrfl_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> hdl/ymrfl_back.sv
// back end: payload buffer and result sequencer with output register
// depends on ymrfl_pkg
`default_nettype none
module ymrfl_back #(
    parameter int LONG_PAYLOAD = ymrfl_pkg::LONG_PAYLOAD_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    input  ymrfl_pkg::t_cmd                  i_cmd,
    output logic                             o_pop,
    output logic                             o_idle,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(LONG_PAYLOAD)-1:0] i_wr_addr,
    input  wire logic [7:0]                  i_wr_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_tx_byte,
    output logic [31:0]                      o_flash_address,
    output logic [15:0]                      o_page_count,
    output logic [255:0]                     o_write_data,
    output logic                             o_last
);
    import ymrfl_pkg::*;

    localparam int AW   = $clog2(LONG_PAYLOAD);
    localparam int ROWS = (LONG_PAYLOAD + 31) / 32;
    localparam int RW   = $clog2(ROWS);
    localparam logic [RW-1:0] LAST_LONG  = RW'(LONG_PAYLOAD / 32 - 1);
    localparam logic [RW-1:0] LAST_SHORT = RW'(SHORT_PAYLOAD / 32 - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACK   = 3'd1;
    localparam logic [2:0] ST_C     = 3'd2;
    localparam logic [2:0] ST_NAK   = 3'd3;
    localparam logic [2:0] ST_ERASE = 3'd4;
    localparam logic [2:0] ST_JUMP  = 3'd5;
    localparam logic [2:0] ST_RD    = 3'd6;
    localparam logic [2:0] ST_WR    = 3'd7;

    logic [255:0]  r_mem [ROWS];
    logic [255:0]  r_rd;
    logic [2:0]    r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [RW-1:0] r_chunk, n_chunk;
    logic          r_ov;

    logic          w_slot, w_load, w_last;
    logic [1:0]    w_kind;
    logic [7:0]    w_tx;
    logic [31:0]   w_addr;
    logic [15:0]   w_pages;
    logic [255:0]  w_data;
    logic [RW-1:0] w_last_chunk;

    assign w_slot       = !r_ov || !i_out_stall;
    assign w_last_chunk = r_cmd.is_long ? LAST_LONG : LAST_SHORT;
    assign o_idle       = (r_state == ST_IDLE);
    assign o_out_valid  = r_ov;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr[AW-1:5]][{i_wr_addr[4:0], 3'b000} +: 8] <= i_wr_data;
        end
        if (r_state == ST_RD) begin
            r_rd <= r_mem[r_chunk];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_chunk = r_chunk;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        w_last  = 1'b0;
        w_kind  = KIND_TX;
        w_tx    = '0;
        w_addr  = '0;
        w_pages = '0;
        w_data  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_chunk = '0;
                    case (i_cmd.op)
                        CMD_C:    n_state = ST_C;
                        CMD_NAK:  n_state = ST_NAK;
                        CMD_DATA: n_state = ST_RD;
                        default:  n_state = ST_ACK;
                    endcase
                end
            end
            ST_ACK: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    w_tx   = B_ACK;
                    case (r_cmd.op)
                        CMD_ACK_C, CMD_START: n_state = ST_C;
                        CMD_END:              n_state = ST_JUMP;
                        default: begin
                            w_last  = 1'b1;
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_C: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    w_tx   = B_C;
                    if (r_cmd.op == CMD_START) begin
                        n_state = ST_ERASE;
                    end else begin
                        w_last  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_NAK: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    w_tx    = B_NAK;
                    w_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_ERASE: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    w_kind  = KIND_ERASE;
                    w_addr  = r_cmd.addr;
                    w_pages = r_cmd.pages;
                    w_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_JUMP: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    w_kind  = KIND_JUMP;
                    w_addr  = r_cmd.addr;
                    w_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    w_kind = KIND_WRITE;
                    w_addr = r_cmd.addr + 32'({r_chunk, 5'b00000});
                    w_data = r_rd;
                    if (r_chunk == w_last_chunk) begin
                        n_state = ST_ACK;
                    end else begin
                        n_chunk = r_chunk + RW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_kind          <= w_kind;
            o_tx_byte       <= w_tx;
            o_flash_address <= w_addr;
            o_page_count    <= w_pages;
            o_write_data    <= w_data;
            o_last          <= w_last;
        end
        r_cmd   <= n_cmd;
        r_chunk <= n_chunk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/ymodem_receiver_flash_loader_core.sv
// top level of the ymodem receiver flash loader: config registers, front, queue, back
// depends on ymrfl_pkg, ymrfl_front, ymrfl_queue, ymrfl_back and the macros header
`default_nettype none
`include "ymodem_receiver_flash_loader_core_macros.svh"
// ymodem receiver with flash loader. each accepted input transaction is one frame byte
// (or a poll tick); the crc-16/xmodem byte update is combinational and registered with
// the byte. on the last byte of a frame the front end classifies the frame and queues at
// most one command; the back end then plays out its results through a registered
// output stage: transmit bytes, an erase request, 32-byte flash writes read from the
// payload buffer (one buffer row per write) or a jump request. while a command is queued
// or being played out the input is stalled, so a frame end holds the input until the
// back end has loaded its last result into the output register, including any output
// stall in between; otherwise one byte per cycle.
// configuration writes are always ready and should only be made while idle.
module ymodem_receiver_flash_loader_core #(
    parameter int LONG_PAYLOAD = ymrfl_pkg::LONG_PAYLOAD_DEF,
    parameter int MAX_FRAME    = ymrfl_pkg::MAX_FRAME_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input transactions
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_end,
    // result transactions
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic [31:0]      o_flash_address,
    output logic [15:0]      o_page_count,
    output logic [63:0]      o_write_data_0,
    output logic [63:0]      o_write_data_1,
    output logic [63:0]      o_write_data_2,
    output logic [63:0]      o_write_data_3,
    output logic             o_last
);
    import ymrfl_pkg::*;

    localparam int AW = $clog2(LONG_PAYLOAD);

    // configuration registers
    logic        r_enable;
    logic [31:0] r_base;
    logic [15:0] r_pages;

    // front to queue
    t_cmd        w_push_cmd, w_q_cmd;
    logic        w_push, w_pop, w_q_empty, w_q_full;
    // front to payload buffer
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    // back status
    logic        w_back_idle;
    logic [255:0] w_data;
    logic        w_accept;

    assign o_cfg_ready = 1'b1;
    // hold input while any command is queued or being played out, keeps the payload buffer safe
    assign o_in_stall  = !(w_q_empty && w_back_idle);
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_base   <= 32'h0800_9000;
            r_pages  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_PAGES:  r_pages  <= i_cfg_data[15:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    ymrfl_front #(
        .LONG_PAYLOAD(LONG_PAYLOAD),
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(w_accept),
        .i_action(i_action),
        .i_rx_byte(i_rx_byte),
        .i_frame_end(i_frame_end),
        .i_update_enable(r_enable),
        .i_image_base(r_base),
        .i_erase_page_count(r_pages),
        .o_cmd(w_push_cmd),
        .o_push(w_push),
        .o_wr_en(w_wr_en),
        .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data)
    );

    ymrfl_queue u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data(w_push_cmd),
        .i_pop(w_pop),
        .o_data(w_q_cmd),
        .o_empty(w_q_empty),
        .o_full(w_q_full)
    );

    ymrfl_back #(
        .LONG_PAYLOAD(LONG_PAYLOAD)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd_valid(!w_q_empty),
        .i_cmd(w_q_cmd),
        .o_pop(w_pop),
        .o_idle(w_back_idle),
        .i_wr_en(w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_kind(o_kind),
        .o_tx_byte(o_tx_byte),
        .o_flash_address(o_flash_address),
        .o_page_count(o_page_count),
        .o_write_data(w_data),
        .o_last(o_last)
    );

    // write chunk split into little-endian words
    assign o_write_data_0 = w_data[63:0];
    assign o_write_data_1 = w_data[127:64];
    assign o_write_data_2 = w_data[191:128];
    assign o_write_data_3 = w_data[255:192];

    // a command is never pushed onto a full queue
    `YM_ASSERT_IMP(a_no_overflow, w_push, !w_q_full)
    // a pushed command is visible to the back end next cycle
    `YM_ASSERT_NXT(a_push_seen, w_push, !w_q_empty || !w_back_idle)
    // payload buffer is never written while the back end reads it
    `YM_ASSERT_IMP(a_buf_safe, w_wr_en, w_back_idle && w_q_empty)
endmodule
`default_nettype wire

>>> tb/ymodem_receiver_flash_loader_core_tb.sv
// self-checking testbench for the ymodem receiver flash loader core
// depends on ymrfl_pkg and the ymodem_receiver_flash_loader_core rtl
`timescale 1ns / 100ps
`default_nettype none
module ymodem_receiver_flash_loader_core_tb;
    import ymrfl_pkg::*;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [31:0] flash_address;
        logic [15:0] page_count;
        logic [63:0] wd0;
        logic [63:0] wd1;
        logic [63:0] wd2;
        logic [63:0] wd3;
        logic        last;
    } t_loader_result;

    // one input transaction
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_rx_item;

    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 2 * (LONG_PAYLOAD_DEF / 32) + 40;
    localparam int MAX_FRAME_LEN = MAX_FRAME_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [7:0]  i_rx_byte;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [31:0] o_flash_address;
    logic [15:0] o_page_count;
    logic [63:0] o_write_data_0;
    logic [63:0] o_write_data_1;
    logic [63:0] o_write_data_2;
    logic [63:0] o_write_data_3;
    logic        o_last;

    ymodem_receiver_flash_loader_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_rx_byte(i_rx_byte), .i_frame_end(i_frame_end),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_kind(o_kind), .o_tx_byte(o_tx_byte),
        .o_flash_address(o_flash_address), .o_page_count(o_page_count),
        .o_write_data_0(o_write_data_0), .o_write_data_1(o_write_data_1),
        .o_write_data_2(o_write_data_2), .o_write_data_3(o_write_data_3),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // shadow copy of the loader state and registers
    // ---------------------------------------------------------------
    logic        sh_enable;
    logic [31:0] sh_base;
    logic [15:0] sh_pages;
    logic [1:0]  sh_phase;
    logic [15:0] sh_block;
    int unsigned sh_index;
    logic [7:0]  sh_type;
    logic [7:0]  sh_hdr_blk;
    logic [7:0]  sh_hdr_cmp;
    logic [15:0] sh_crc;
    logic [15:0] sh_rx_crc;
    logic [7:0]  sh_payload [LONG_PAYLOAD_DEF];

    t_loader_result expected_results[$];
    int  fail_count;
    int  idle_cycles;
    bit  long_hold_req;

    // crc-16/xmodem, msb first, init zero
    function automatic logic [15:0] xmodem_crc_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        return c;
    endfunction

    task automatic push_result(logic [1:0] kind, logic [7:0] tx, logic [31:0] addr,
                               logic [15:0] pg, logic [255:0] data);
        t_loader_result r;
        r.kind = kind;
        r.tx_byte = tx;
        r.flash_address = addr;
        r.page_count = pg;
        r.wd0 = data[63:0];
        r.wd1 = data[127:64];
        r.wd2 = data[191:128];
        r.wd3 = data[255:192];
        r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    // absorb one frame byte into the shadow frame state
    task automatic absorb_byte(logic [7:0] b);
        int unsigned plen;
        int unsigned q;
        if (sh_index == 0) begin
            sh_type = b;
            sh_crc = 16'h0;
            sh_rx_crc = 16'h0;
        end else if (sh_index == 1) begin
            sh_hdr_blk = b;
        end else if (sh_index == 2) begin
            sh_hdr_cmp = b;
        end
        plen = (sh_type == T_SOH) ? SHORT_PAYLOAD : (sh_type == T_STX) ? LONG_PAYLOAD_DEF : 0;
        if (plen != 0 && sh_index >= 3) begin
            q = sh_index - 3;
            if (q < plen) begin
                sh_payload[q] = b;
                sh_crc = xmodem_crc_step(sh_crc, b);
            end else if (q == plen) begin
                sh_rx_crc = {b, 8'h00};
            end else if (q == plen + 1) begin
                sh_rx_crc[7:0] = b;
            end
        end
        if (sh_index < MAX_FRAME_LEN)
            sh_index++;
    endtask

    // decide what the end of the frame causes
    task automatic close_frame();
        int unsigned plen;
        logic [31:0] addr;
        logic [255:0] chunk;
        if (sh_type == T_EOT) begin
            if (sh_phase == PH_DATA) begin
                sh_phase = PH_EOT2;
                push_result(KIND_TX, B_NAK, 0, 0, 0);
            end else if (sh_phase == PH_EOT2) begin
                sh_phase = PH_END;
                push_result(KIND_TX, B_ACK, 0, 0, 0);
                push_result(KIND_TX, B_C, 0, 0, 0);
            end
            return;
        end
        if (sh_type == T_SOH) plen = SHORT_PAYLOAD;
        else if (sh_type == T_STX) plen = LONG_PAYLOAD_DEF;
        else return;
        if (sh_index < plen + 5 || sh_crc != sh_rx_crc) return;
        if (sh_hdr_cmp != ~sh_hdr_blk) return;
        if (sh_phase == PH_START && sh_hdr_blk == 8'h00) begin
            sh_phase = PH_DATA;
            sh_block = 16'd1;
            push_result(KIND_TX, B_ACK, 0, 0, 0);
            push_result(KIND_TX, B_C, 0, 0, 0);
            push_result(KIND_ERASE, 8'h00, sh_base, sh_pages, 0);
        end else if (sh_phase == PH_END && sh_hdr_blk == 8'h00) begin
            sh_phase = PH_START;
            push_result(KIND_TX, B_ACK, 0, 0, 0);
            push_result(KIND_JUMP, 8'h00, sh_base, 0, 0);
        end else if (sh_phase == PH_DATA && sh_hdr_blk == sh_block[7:0]) begin
            addr = sh_base + 32'(16'(sh_block - 16'd1)) * plen;
            for (int c = 0; c < plen / 32; c++) begin
                for (int k = 0; k < 32; k++)
                    chunk[k*8 +: 8] = sh_payload[c*32 + k];
                push_result(KIND_WRITE, 8'h00, addr + 32'(c * 32), 0, chunk);
            end
            sh_block = sh_block + 16'd1;
            push_result(KIND_TX, B_ACK, 0, 0, 0);
        end
    endtask

    // predictor entry point for one accepted input transaction
    task automatic predict_loader_step(t_rx_item it);
        int before_n;
        before_n = expected_results.size();
        if (!sh_enable) return;
        if (it.action) begin
            if (sh_phase == PH_START)
                push_result(KIND_TX, B_C, 0, 0, 0);
        end else begin
            absorb_byte(it.rx_byte);
            if (it.frame_end) begin
                close_frame();
                sh_index = 0;
            end
        end
        if (expected_results.size() > before_n)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // output side: random stall, compare each result transaction
    // ---------------------------------------------------------------
    int out_wait;
    int hold_count;
    bit hold_taken;

    always @(posedge i_clk) begin
        t_loader_result exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
            out_wait = 0;
            hold_count = 0;
            hold_taken = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: kind %0d", o_kind);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_kind !== exp_r.kind) begin
                        $error("kind expected %0h actual %0h", exp_r.kind, o_kind);
                        fail_count++;
                    end
                    if (o_tx_byte !== exp_r.tx_byte) begin
                        $error("tx_byte expected %0h actual %0h", exp_r.tx_byte, o_tx_byte);
                        fail_count++;
                    end
                    if (o_flash_address !== exp_r.flash_address) begin
                        $error("flash_address expected %0h actual %0h",
                               exp_r.flash_address, o_flash_address);
                        fail_count++;
                    end
                    if (o_page_count !== exp_r.page_count) begin
                        $error("page_count expected %0h actual %0h",
                               exp_r.page_count, o_page_count);
                        fail_count++;
                    end
                    if (o_write_data_0 !== exp_r.wd0) begin
                        $error("write_data_0 expected %0h actual %0h", exp_r.wd0, o_write_data_0);
                        fail_count++;
                    end
                    if (o_write_data_1 !== exp_r.wd1) begin
                        $error("write_data_1 expected %0h actual %0h", exp_r.wd1, o_write_data_1);
                        fail_count++;
                    end
                    if (o_write_data_2 !== exp_r.wd2) begin
                        $error("write_data_2 expected %0h actual %0h", exp_r.wd2, o_write_data_2);
                        fail_count++;
                    end
                    if (o_write_data_3 !== exp_r.wd3) begin
                        $error("write_data_3 expected %0h actual %0h", exp_r.wd3, o_write_data_3);
                        fail_count++;
                    end
                    if (o_last !== exp_r.last) begin
                        $error("last expected %0h actual %0h", exp_r.last, o_last);
                        fail_count++;
                    end
                end
                out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                if ($urandom_range(0, 2) == 0) out_wait = 0;
            end
            // long hold-off requested by the sender side, counted here, once per request
            if (!long_hold_req) begin
                hold_taken = 0;
            end else if (!hold_taken) begin
                hold_count = 300;
                hold_taken = 1;
            end
            if (hold_count > 0) begin
                hold_count--;
                i_out_stall <= 1'b1;
            end else if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // input side helpers
    // ---------------------------------------------------------------
    bit  gaps_on;

    // drop valid and scramble the idle payload
    task automatic release_input();
        i_in_valid  <= 1'b0;
        i_action    <= 1'($urandom_range(0, 1));
        i_rx_byte   <= 8'($urandom_range(0, 255));
        i_frame_end <= 1'($urandom_range(0, 1));
    endtask

    // offer one input transaction and wait for its acceptance
    task automatic send_item(t_rx_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            release_input();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= it.action;
        i_rx_byte   <= it.rx_byte;
        i_frame_end <= it.frame_end;
        do @(posedge i_clk); while (o_in_stall);
        predict_loader_step(it);
    endtask

    task automatic send_byte(logic [7:0] b, logic fe);
        t_rx_item it;
        it.action = 1'b0;
        it.rx_byte = b;
        it.frame_end = fe;
        send_item(it);
    endtask

    task automatic send_poll();
        t_rx_item it;
        it.action = 1'b1;
        it.rx_byte = 8'($urandom_range(0, 255));
        it.frame_end = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    // whole frame: type, block, complement, payload, crc; optional faults
    task automatic send_frame(logic [7:0] ftype, logic [7:0] blk, bit bad_cmp, bit bad_crc,
                              int short_by, int extra, bit zero_fill, bit ones_fill);
        int unsigned plen;
        int unsigned total;
        logic [7:0] body [$];
        logic [15:0] crc;
        logic [7:0] b;
        plen = (ftype == T_STX) ? LONG_PAYLOAD_DEF : SHORT_PAYLOAD;
        crc = 16'h0;
        body.push_back(ftype);
        body.push_back(blk);
        body.push_back(bad_cmp ? blk : ~blk);
        for (int i = 0; i < plen; i++) begin
            b = zero_fill ? 8'h00 : ones_fill ? 8'hFF : 8'($urandom_range(0, 255));
            body.push_back(b);
            crc = xmodem_crc_step(crc, b);
        end
        if (bad_crc) crc = crc ^ 16'h0001;
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        for (int i = 0; i < extra; i++) body.push_back(8'($urandom_range(0, 255)));
        total = body.size() - short_by;
        for (int i = 0; i < total; i++)
            send_byte(body[i], i == total - 1);
    endtask

    task automatic send_eot();
        send_byte(T_EOT, 1'b1);
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain_results();
        release_input();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        release_input();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ENABLE) sh_enable = val[0];
        else if (idx == CFG_BASE) sh_base = val;
        else if (idx == CFG_PAGES) sh_pages = val[15:0];
        @(posedge i_clk);
    endtask

    // a complete transfer: start, some data blocks, eot pair, end
    task automatic send_session(int nblocks, bit use_long);
        send_poll();
        send_frame(T_SOH, 8'h00, 0, 0, 0, 0, 0, 0);
        for (int i = 1; i <= nblocks; i++)
            send_frame(use_long && i == 1 ? T_STX : T_SOH, 8'(i), 0, 0, 0, 0, 0, 0);
        send_eot();
        send_eot();
        send_frame(T_SOH, 8'h00, 0, 0, 0, 0, 0, 0);
    endtask

    // ---------------------------------------------------------------
    // directed table: small items with results read off at a glance
    // ---------------------------------------------------------------
    typedef struct {
        t_rx_item   item;
        bit         has_result;
        logic [7:0] tx;
    } t_table_row;

    t_table_row dir_table [] = '{
        '{'{1'b1, 8'hFF, 1'b1}, 1'b1, B_C},       // poll while waiting to start
        '{'{1'b1, 8'h00, 1'b0}, 1'b1, B_C},
        '{'{1'b0, 8'h04, 1'b1}, 1'b0, 8'h00},     // eot while waiting is ignored
        '{'{1'b0, 8'hFF, 1'b1}, 1'b0, 8'h00},     // unknown type
        '{'{1'b0, 8'h01, 1'b0}, 1'b0, 8'h00},     // soh cut short
        '{'{1'b0, 8'h00, 1'b1}, 1'b0, 8'h00},
        '{'{1'b0, 8'h02, 1'b1}, 1'b0, 8'h00}      // stx with one byte
    };

    int n_items;
    int sel;

    initial begin
        t_rx_item it;
        t_table_row row;
        fail_count = 0;
        long_hold_req = 0;
        gaps_on = 1;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ENABLE;
        i_cfg_data = 32'h0;
        i_in_valid = 1'b0;
        i_action = 1'b0;
        i_rx_byte = 8'h00;
        i_frame_end = 1'b0;
        sh_enable = 1'b0;
        sh_base = 32'h0800_9000;
        sh_pages = 16'h0;
        sh_phase = PH_START;
        sh_block = 16'h0;
        sh_index = 0;
        sh_type = 8'h0;
        sh_hdr_blk = 8'h0;
        sh_hdr_cmp = 8'h0;
        sh_crc = 16'h0;
        sh_rx_crc = 16'h0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled after reset: nothing comes out
        send_poll();
        send_byte(T_SOH, 1'b1);
        drain_results();
        write_reg(CFG_ENABLE, 32'h1);

        // directed rows, with results typed in where obvious
        foreach (dir_table[i]) begin
            row = dir_table[i];
            send_item(row.item);
            if (row.has_result && expected_results[$].tx_byte !== row.tx) begin
                $error("tx_byte expected %0h actual %0h", row.tx, expected_results[$].tx_byte);
                fail_count++;
            end
        end
        drain_results();

        // extremes of the registers, a full short session with a long block
        write_reg(CFG_BASE, 32'hFFFF_FFE0);
        write_reg(CFG_PAGES, 32'h0000_FFFF);
        send_session(2, 1);
        drain_results();
        write_reg(CFG_BASE, 32'h0);
        write_reg(CFG_PAGES, 32'h0);
        // faulty frames: bad complement, bad crc, short, wrong block, long tail
        send_frame(T_SOH, 8'h00, 1, 0, 0, 0, 0, 0);
        send_frame(T_SOH, 8'h00, 0, 1, 0, 0, 1, 0);
        send_frame(T_SOH, 8'h00, 0, 0, 1, 0, 0, 1);
        send_frame(T_SOH, 8'h00, 0, 0, 0, 3, 0, 1);
        send_frame(T_SOH, 8'h05, 0, 0, 0, 0, 0, 0);
        send_frame(T_SOH, 8'h01, 0, 0, 0, 0, 0, 0);
        send_poll();
        drain_results();

        // disabled mid-frame: partial frame kept, input ignored
        send_byte(T_SOH, 1'b0);
        write_reg(CFG_ENABLE, 32'h0);
        send_byte(8'h55, 1'b1);
        send_poll();
        drain_results();
        write_reg(CFG_ENABLE, 32'h1);
        send_byte(8'hFF, 1'b1);

        // random part: mostly well formed frames, some noise and faults
        write_reg(CFG_BASE, $urandom);
        write_reg(CFG_PAGES, $urandom_range(0, 65535));
        n_items = 0;
        while (n_items < 170) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 15);
            if (n_items == 40) begin
                // receiver holds off while the sender keeps offering items
                gaps_on = 0;
                long_hold_req = 1;
                send_frame(T_SOH, sh_phase == PH_DATA ? sh_block[7:0] : 8'h00,
                           0, 0, 0, 0, 0, 0);
                send_poll();
                send_eot();
                long_hold_req = 0;
            end else if (n_items == 90) begin
                // sender pauses until every result is out
                release_input();
                while (expected_results.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end else if (sel < 9) begin
                if (sh_phase == PH_DATA)
                    send_frame($urandom_range(0, 7) == 0 ? T_STX : T_SOH, sh_block[7:0],
                               0, 0, 0, $urandom_range(0, 1), 0, 0);
                else if (sh_phase == PH_EOT2)
                    send_eot();
                else
                    send_frame(T_SOH, 8'h00, 0, 0, 0, 0, 0, 0);
            end else if (sel < 11) begin
                send_eot();
            end else if (sel < 13) begin
                send_poll();
            end else if (sel < 14) begin
                send_frame(T_SOH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), $urandom_range(0, 3), 0, 0, 0);
            end else begin
                it.action = 1'($urandom_range(0, 1));
                it.rx_byte = 8'($urandom_range(0, 255));
                it.frame_end = 1'b1;
                send_item(it);
            end
            n_items++;
            if (n_items % 60 == 0) begin
                drain_results();
                write_reg(CFG_BASE, ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom);
                write_reg(CFG_PAGES, $urandom_range(0, 65535));
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
